// ===== src/apgs_pkg.sv =====
// ============================================================================
// apgs_pkg
// Shared widths, codes and types of the aligned pair affine gap score core.
// ============================================================================
package apgs_pkg;

    localparam int SYM_W   = 5;
    localparam int VAL_W   = 16;
    localparam int LEN_W   = 16;
    localparam int SCORE_W = 32;
    localparam int PEN_W   = 12;
    localparam int MODE_W  = 2;
    localparam int FUNC_W  = 2;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;

    // end penalty: gap_open + len * gap_extend, and the sum of both ends
    localparam int PROD_W  = LEN_W + PEN_W;
    localparam int ENDP_W  = PROD_W + 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COLUMN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] REG_FIRST_LETTER = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAP_OPEN     = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAP_EXTEND   = 2'd2;
    localparam logic [IDX_W-1:0] REG_END_GAP_MODE = 2'd3;

    typedef struct packed {
        logic [SYM_W-1:0]  first_letter;
        logic [PEN_W-1:0]  gap_open;
        logic [PEN_W-1:0]  gap_extend;
        logic [MODE_W-1:0] end_gap_mode;
    } apgs_cfg_t;

    typedef struct packed {
        logic              is_fin;
        logic              let_a;
        logic              let_b;
        logic [VAL_W-1:0]  sub;
        logic [ENDP_W-1:0] pen_tail;
        logic [ENDP_W-1:0] pen_all;
    } apgs_entry_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } apgs_qstat_t;

endpackage

// ===== src/apgs_front.sv =====
// ============================================================================
// apgs_front
// Accepts items, writes and reads the substitution table, classifies
// columns and prepares end-gap penalties for the queue.
// ============================================================================
module apgs_front #(
    parameter int SYMBOLS = 32,
    parameter int MAX_LEN = 65535
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [apgs_pkg::FUNC_W-1:0]      func,
    input  logic [apgs_pkg::SYM_W-1:0]       sym_a,
    input  logic [apgs_pkg::SYM_W-1:0]       sym_b,
    input  logic signed [apgs_pkg::VAL_W-1:0] table_value,
    input  logic [apgs_pkg::LEN_W-1:0]       lead_gap,
    input  logic [apgs_pkg::LEN_W-1:0]       tail_gap,
    input  apgs_pkg::apgs_cfg_t              cfg,
    input  apgs_pkg::apgs_qstat_t            qstat,
    output logic                             push,
    output apgs_pkg::apgs_entry_t            push_entry
);
    import apgs_pkg::*;

    localparam int DEPTH   = SYMBOLS * SYMBOLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LEN_CAP = (MAX_LEN < 65535) ? MAX_LEN : 65535;

    logic signed [VAL_W-1:0] tab_mem [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    logic              accept;
    logic              in_tab;
    logic [ADDR_W-1:0] tab_addr;
    logic              tab_we;
    logic              tab_re;
    logic              keep;
    logic [LEN_W-1:0]  lead_cl;
    logic [LEN_W-1:0]  tail_cl;
    logic              s1_ready;
    logic              s2_ready;

    logic              s1_valid_reg;
    logic              s1_fin_reg;
    logic              s1_let_a_reg;
    logic              s1_let_b_reg;
    logic              s1_in_tab_reg;
    logic [LEN_W-1:0]  s1_lead_reg;
    logic [LEN_W-1:0]  s1_tail_reg;
    logic              s1_lead_en_reg;
    logic              s1_tail_en_reg;

    logic              s2_valid_reg;
    logic              s2_fin_reg;
    logic              s2_let_a_reg;
    logic              s2_let_b_reg;
    logic [VAL_W-1:0]  s2_sub_reg;
    logic [PROD_W-1:0] s2_lead_prod_reg;
    logic [PROD_W-1:0] s2_tail_prod_reg;
    logic              s2_lead_en_reg;
    logic              s2_tail_en_reg;

    logic [ENDP_W-1:0] lead_pen;
    logic [ENDP_W-1:0] tail_pen;

    assign s2_ready = !s2_valid_reg || !qstat.full;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && !in_stall;

    assign in_tab   = (int'(sym_a) < SYMBOLS) && (int'(sym_b) < SYMBOLS);
    assign tab_addr = ADDR_W'(ADDR_W'(sym_a) * ADDR_W'(SYMBOLS)) + ADDR_W'(sym_b);
    assign tab_we   = accept && (func == FUNC_LOAD) && in_tab;
    assign tab_re   = accept && (func == FUNC_COLUMN);
    // loads and unused codes finish at the table
    assign keep     = (func == FUNC_COLUMN) || (func == FUNC_FINISH);

    assign lead_cl = (int'(lead_gap) > LEN_CAP) ? LEN_W'(LEN_CAP) : lead_gap;
    assign tail_cl = (int'(tail_gap) > LEN_CAP) ? LEN_W'(LEN_CAP) : tail_gap;

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_addr] <= table_value;
        end
        if (tab_re)
        begin
            rd_data_reg <= tab_mem[tab_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= accept && keep;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fin_reg     <= (func == FUNC_FINISH);
            s1_let_a_reg   <= (sym_a >= cfg.first_letter);
            s1_let_b_reg   <= (sym_b >= cfg.first_letter);
            s1_in_tab_reg  <= in_tab;
            s1_lead_reg    <= lead_cl;
            s1_tail_reg    <= tail_cl;
            s1_lead_en_reg <= cfg.end_gap_mode[1] && (lead_gap != '0);
            s1_tail_en_reg <= cfg.end_gap_mode[0] && (tail_gap != '0);
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_fin_reg       <= s1_fin_reg;
            s2_let_a_reg     <= s1_let_a_reg;
            s2_let_b_reg     <= s1_let_b_reg;
            // a pair that leaves the table adds nothing
            s2_sub_reg       <= (s1_in_tab_reg && s1_let_a_reg && s1_let_b_reg)
                                ? rd_data_reg : '0;
            s2_lead_prod_reg <= PROD_W'(s1_lead_reg) * PROD_W'(cfg.gap_extend);
            s2_tail_prod_reg <= PROD_W'(s1_tail_reg) * PROD_W'(cfg.gap_extend);
            s2_lead_en_reg   <= s1_lead_en_reg;
            s2_tail_en_reg   <= s1_tail_en_reg;
        end
    end

    assign lead_pen = s2_lead_en_reg
                      ? ENDP_W'(s2_lead_prod_reg) + ENDP_W'(cfg.gap_open) : '0;
    assign tail_pen = s2_tail_en_reg
                      ? ENDP_W'(s2_tail_prod_reg) + ENDP_W'(cfg.gap_open) : '0;

    assign push                = s2_valid_reg && !qstat.full;
    assign push_entry.is_fin   = s2_fin_reg;
    assign push_entry.let_a    = s2_let_a_reg;
    assign push_entry.let_b    = s2_let_b_reg;
    assign push_entry.sub      = s2_sub_reg;
    assign push_entry.pen_tail = tail_pen;
    assign push_entry.pen_all  = lead_pen + tail_pen;

endmodule

// ===== src/apgs_queue.sv =====
// ============================================================================
// apgs_queue
// Short FIFO between the front and the back of the score core.
// ============================================================================
module apgs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  apgs_pkg::apgs_entry_t push_entry,
    input  logic                  pop,
    output apgs_pkg::apgs_entry_t head,
    output apgs_pkg::apgs_qstat_t qstat
);
    import apgs_pkg::*;

    apgs_entry_t        q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign qstat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;
    assign head        = q_mem[rd_ptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/apgs_back.sv =====
// ============================================================================
// apgs_back
// Applies queued columns to the running score with affine gap tracking,
// closes a pair on finish and holds the result in the output register.
// ============================================================================
module apgs_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  apgs_pkg::apgs_cfg_t                cfg,
    input  apgs_pkg::apgs_qstat_t              qstat,
    input  apgs_pkg::apgs_entry_t              head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [apgs_pkg::SCORE_W-1:0] score
);
    import apgs_pkg::*;

    localparam int ACC_W = SCORE_W + 4;

    logic signed [SCORE_W-1:0] running_reg;
    logic                      gap_a_reg;
    logic                      gap_b_reg;
    logic                      seen_reg;
    logic                      out_valid_reg;
    logic signed [SCORE_W-1:0] score_reg;

    logic [ACC_W-1:0]          gap_cost;
    logic [ACC_W-1:0]          delta;
    logic [ACC_W-1:0]          sum;
    logic [SCORE_W-1:0]        sat;
    logic                      fits;

    // finish waits for the output register; columns never do
    assign pop = !qstat.empty && (!head.is_fin || !out_valid_reg || !out_stall);

    always_comb
    begin
        gap_cost = ACC_W'(cfg.gap_extend);
        if (head.let_a && !gap_b_reg)
        begin
            gap_cost = ACC_W'(cfg.gap_extend) + ACC_W'(cfg.gap_open);
        end
        else if (!head.let_a && head.let_b && !gap_a_reg)
        begin
            gap_cost = ACC_W'(cfg.gap_extend) + ACC_W'(cfg.gap_open);
        end

        if (head.is_fin)
        begin
            delta = -(seen_reg ? ACC_W'(head.pen_all) : ACC_W'(head.pen_tail));
        end
        else if (head.let_a && head.let_b)
        begin
            delta = {{(ACC_W-VAL_W){head.sub[VAL_W-1]}}, head.sub};
        end
        else if (head.let_a || head.let_b)
        begin
            delta = -gap_cost;
        end
        else
        begin
            delta = '0;
        end

        sum  = {{(ACC_W-SCORE_W){running_reg[SCORE_W-1]}}, running_reg} + delta;
        fits = (sum[ACC_W-1:SCORE_W-1] == '0) || (sum[ACC_W-1:SCORE_W-1] == '1);
        if (fits)
        begin
            sat = sum[SCORE_W-1:0];
        end
        else if (sum[ACC_W-1])
        begin
            sat = {1'b1, {(SCORE_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(SCORE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            gap_a_reg     <= 1'b0;
            gap_b_reg     <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head.is_fin)
            begin
                out_valid_reg <= 1'b1;
                running_reg   <= '0;
                gap_a_reg     <= 1'b0;
                gap_b_reg     <= 1'b0;
                seen_reg      <= 1'b0;
            end
            else
            begin
                if (!out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (pop)
                begin
                    running_reg <= sat;
                    seen_reg    <= 1'b1;
                    if (head.let_a && head.let_b)
                    begin
                        gap_a_reg <= 1'b0;
                        gap_b_reg <= 1'b0;
                    end
                    else if (head.let_a)
                    begin
                        gap_a_reg <= 1'b0;
                        gap_b_reg <= 1'b1;
                    end
                    else if (head.let_b)
                    begin
                        gap_a_reg <= 1'b1;
                        gap_b_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.is_fin)
        begin
            score_reg <= sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;

endmodule

// ===== src/aligned_pair_affine_gap_score_core.sv =====
// ============================================================================
// aligned_pair_affine_gap_score_core
// Affine-gap score of one pair of aligned sequences, column by column.
// ============================================================================
// Input channel (in_valid / in_stall): func selects a table load, an aligned
// column or a finish. An item is taken on a rising edge with in_valid high
// and in_stall low. Loads write the substitution table at once; columns and
// finishes pass a two-stage front (table read, end-gap multiply) into a
// four-entry queue, and the back applies one queued item per cycle while
// no finish waits on a stalled output. Output channel (out_valid /
// out_stall): one score per finish item, held in an output register until
// taken. Throughput: one item per cycle while nothing stalls, set by the
// accumulate in the back and the one-port table read in the front. A
// stalled output blocks only a finish at the queue head; columns keep
// draining, and the input stalls only once the queue and both front stages
// are full. Reset clears the pair state, the pipeline and the queue and
// loads the register defaults; the table holds nothing until loaded. The
// user writes configuration (cfg_we, cfg_index, cfg_data) only while the
// core is idle; the core does not enforce it.
// ============================================================================
module aligned_pair_affine_gap_score_core #(
    parameter int SYMBOLS = 32,
    parameter int MAX_LEN = 65535
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [apgs_pkg::IDX_W-1:0]         cfg_index,
    input  logic [apgs_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [apgs_pkg::FUNC_W-1:0]        func,
    input  logic [apgs_pkg::SYM_W-1:0]         sym_a,
    input  logic [apgs_pkg::SYM_W-1:0]         sym_b,
    input  logic signed [apgs_pkg::VAL_W-1:0]  table_value,
    input  logic [apgs_pkg::LEN_W-1:0]         lead_gap,
    input  logic [apgs_pkg::LEN_W-1:0]         tail_gap,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [apgs_pkg::SCORE_W-1:0] score
);
    import apgs_pkg::*;

    apgs_cfg_t   cfg_reg;
    apgs_qstat_t qstat;
    apgs_entry_t push_entry;
    apgs_entry_t head;
    logic        push;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_letter <= SYM_W'(1);
            cfg_reg.gap_open     <= '0;
            cfg_reg.gap_extend   <= '0;
            cfg_reg.end_gap_mode <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_LETTER: cfg_reg.first_letter <= cfg_data[SYM_W-1:0];
                REG_GAP_OPEN:     cfg_reg.gap_open     <= cfg_data[PEN_W-1:0];
                REG_GAP_EXTEND:   cfg_reg.gap_extend   <= cfg_data[PEN_W-1:0];
                REG_END_GAP_MODE: cfg_reg.end_gap_mode <= cfg_data[MODE_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    apgs_front #(
        .SYMBOLS (SYMBOLS),
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .sym_a       (sym_a),
        .sym_b       (sym_b),
        .table_value (table_value),
        .lead_gap    (lead_gap),
        .tail_gap    (tail_gap),
        .cfg         (cfg_reg),
        .qstat       (qstat),
        .push        (push),
        .push_entry  (push_entry)
    );

    apgs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    apgs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .score     (score)
    );

    // input may stall only when the queue is full behind a full front
    assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.full |-> !in_stall)
        else $error("input stalled with room in the queue");

    // a result appears only after the back retires a finish item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pop && head.is_fin))
        else $error("result without a retired finish item");

    assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    // never retire a finish while the held result is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !(pop && head.is_fin))
        else $error("finish retired over a stalled result");

endmodule
